// ----- hdl/bdq_pkg.sv -----
// Package for the byte deque with search: sizes, codes, FSM states and
// the command/status structs between controller and datapath. No dependencies.
`default_nettype none

package bdq_pkg;

    localparam int DEPTH     = 64;
    localparam int PTR_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int FIELD_W   = 7;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    typedef enum logic [2:0] {
        CMD_APPEND    = 3'd0,
        CMD_REM_FIRST = 3'd1,
        CMD_REM_LAST  = 3'd2,
        CMD_FIND      = 3'd3,
        CMD_REVERSE   = 3'd4,
        CMD_CLEAR     = 3'd5
    } cmd_code_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_DISPATCH,
        FSM_SCAN,
        FSM_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic is_find;
        logic empty;
        logic scan_done;
        logic out_busy;
    } dp_stat_t;

endpackage

`default_nettype wire

// ----- hdl/bdq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bdq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/bdq_ctrl.sv -----
// Controller FSM for the byte deque: sequences accept, search and commit.
// Depends on bdq_pkg.
`default_nettype none

module bdq_ctrl import bdq_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FSM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            FSM_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = FSM_DISPATCH;
                end
            end
            FSM_DISPATCH: begin
                if (stat.is_find && !stat.empty) begin
                    cmd.scan_start = 1'b1;
                    state_next     = FSM_SCAN;
                end else begin
                    state_next = FSM_FINISH;
                end
            end
            FSM_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done) begin
                    state_next = FSM_FINISH;
                end
            end
            FSM_FINISH: begin
                if (!stat.out_busy) begin
                    cmd.commit = 1'b1;
                    state_next = FSM_IDLE;
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/bdq_dp.sv -----
// Datapath for the byte deque: ring pointers, entry RAM, search pipeline
// and output register. Depends on bdq_pkg and bdq_ram.
`default_nettype none

module bdq_dp import bdq_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 m_tready,
    output logic                      m_tvalid,
    output logic      [M_TDATA_W-1:0] m_tdata,
    input  wire dp_cmd_t              cmd,
    output dp_stat_t                  stat
);

    localparam int SUM_W = PTR_W + 1;

    function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] front,
                                                 input logic [PTR_W-1:0] pos,
                                                 input logic             flip);
        logic [SUM_W-1:0] sum;
        if (flip) begin
            sum = {1'b0, front} + SUM_W'(DEPTH) - {1'b0, pos};
        end else begin
            sum = {1'b0, front} + {1'b0, pos};
        end
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    logic [PTR_W-1:0]     front_reg, front_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 flip_reg, flip_next;
    logic                 pend_reg, pend_next;
    logic                 found_reg, found_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [2:0]           cmd_reg, cmd_next;
    logic [7:0]           key_reg, key_next;
    logic [CNT_W-1:0]     issue_reg, issue_next;
    logic [PTR_W-1:0]     cmpi_reg, cmpi_next;
    logic [CNT_W-1:0]     pos_reg, pos_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic             rd_en;
    logic [PTR_W-1:0] rd_addr;
    logic [7:0]       rd_data;
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    logic             hit;
    logic             last;
    status_t          res_status;
    logic             res_found;
    logic [CNT_W-1:0] res_pos;

    bdq_ram #(
        .WIDTH(8),
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(key_reg),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg    <= '0;
            count_reg    <= '0;
            flip_reg     <= 1'b0;
            pend_reg     <= 1'b0;
            found_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            front_reg    <= front_next;
            count_reg    <= count_next;
            flip_reg     <= flip_next;
            pend_reg     <= pend_next;
            found_reg    <= found_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        key_reg     <= key_next;
        issue_reg   <= issue_next;
        cmpi_reg    <= cmpi_next;
        pos_reg     <= pos_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign rd_addr = slot_of(front_reg, issue_reg[PTR_W-1:0], flip_reg);
    assign rd_en   = cmd.scan_step && (issue_reg < count_reg);
    assign hit     = pend_reg && (rd_data == key_reg);
    assign last    = pend_reg && (CNT_W'(cmpi_reg) == count_reg - CNT_W'(1));
    assign wr_addr = slot_of(front_reg, count_reg[PTR_W-1:0], flip_reg);

    always_comb begin
        front_next    = front_reg;
        count_next    = count_reg;
        flip_next     = flip_reg;
        pend_next     = pend_reg;
        found_next    = found_reg;
        m_tvalid_next = m_tvalid_reg;
        cmd_next      = cmd_reg;
        key_next      = key_reg;
        issue_next    = issue_reg;
        cmpi_next     = cmpi_reg;
        pos_next      = pos_reg;
        m_tdata_next  = m_tdata_reg;
        wr_en         = 1'b0;
        res_status    = STAT_OK;
        res_found     = 1'b0;
        res_pos       = '0;

        if (cmd.load) begin
            cmd_next   = s_tdata[2:0];
            key_next   = s_tdata[10:3];
            found_next = 1'b0;
            pos_next   = '0;
        end

        if (cmd.scan_start) begin
            issue_next = '0;
            pend_next  = 1'b0;
        end

        if (cmd.scan_step) begin
            pend_next = rd_en;
            if (rd_en) begin
                issue_next = issue_reg + CNT_W'(1);
                cmpi_next  = issue_reg[PTR_W-1:0];
            end
            if (hit) begin
                found_next = 1'b1;
                pos_next   = CNT_W'(cmpi_reg) + CNT_W'(1);
            end
        end

        if (cmd.commit) begin
            case (cmd_reg)
                CMD_APPEND: begin
                    if (count_reg == CNT_W'(DEPTH)) begin
                        res_status = STAT_FULL;
                    end else begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                CMD_REM_FIRST: begin
                    if (count_reg == '0) begin
                        res_status = STAT_EMPTY;
                    end else begin
                        front_next = slot_of(front_reg, PTR_W'(1), flip_reg);
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                CMD_REM_LAST: begin
                    if (count_reg == '0) begin
                        res_status = STAT_EMPTY;
                    end else begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                CMD_FIND: begin
                    res_found = found_reg;
                    res_pos   = pos_reg;
                end
                CMD_REVERSE: begin
                    if (count_reg != '0) begin
                        front_next = slot_of(front_reg,
                                             PTR_W'(count_reg - CNT_W'(1)), flip_reg);
                    end
                    flip_next = !flip_reg;
                end
                CMD_CLEAR: begin
                    front_next = '0;
                    count_next = '0;
                    flip_next  = 1'b0;
                end
                default: begin
                end
            endcase
            m_tvalid_next = 1'b1;
            m_tdata_next  = {7'b0, FIELD_W'(count_next), FIELD_W'(res_pos), res_found,
                             res_status};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    assign stat.is_find   = (cmd_reg == CMD_FIND);
    assign stat.empty     = (count_reg == '0);
    assign stat.scan_done = hit || last;
    assign stat.out_busy  = m_tvalid_reg && !m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// ----- hdl/byte_deque_with_search_top.sv -----
// Channel | dir | tdata fields, lowest bit up
// s_      | in  | cmd[2:0], data[10:3], zero pad to 16 bits
// m_      | out | status[1:0], found[2], position[9:3], length[16:10], zero pad to 24 bits
//
// One word at a time. Non-search commands: the result is registered after the dispatch
// and finish steps, and the next word is accepted once the controller is back in idle.
// Search: the scan ends at the first match or after the last entry, then the finish step
// registers the result; the RAM read port walks one entry per cycle.
// Reset (aresetn low, synchronous) empties the list; the RAM needs no clearing.
// A new word is accepted while the previous result still waits in the output
// register; a stalled m_ side holds the next result in the controller's finish step.
// Top level of the byte deque with search. Depends on bdq_pkg, bdq_ctrl, bdq_dp.
`default_nettype none

module byte_deque_with_search_top import bdq_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,  // cmd[2:0], data[10:3]
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata   // status, found, position, length
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    bdq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bdq_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .m_tready(m_tready),
        .m_tvalid(m_tvalid),
        .m_tdata (m_tdata),
        .cmd     (cmd),
        .stat    (stat)
    );

endmodule

`default_nettype wire

// ----- hdl/bdq_checker.sv -----
// Port-level checker for the byte deque, bound to the top level.
// Depends on bdq_pkg.
`default_nettype none

module bdq_checker import bdq_pkg::*; (
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic [S_TDATA_W-1:0] s_tdata,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word accepted before the first finished");

    a_found_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2] == (m_tdata[9:3] != '0)))
        else $error("found flag and position disagree");

    a_err_no_find: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] != STAT_OK) |-> !m_tdata[2] && (m_tdata[1:0] != 2'd3))
        else $error("error status with a search hit or bad code");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind byte_deque_with_search_top bdq_checker u_bdq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

`default_nettype wire
